// ----- rtl/blbt_pkg.sv -----
// Package for the band level and beat tracker: payload structs, constants, tables.
// No dependencies.
package blbt_pkg;

  localparam int BAND_COUNT_DEF = 14;
  localparam int LEVEL_TOP_DEF  = 60;
  localparam int VOTE_BANDS_DEF = 4;
  localparam int TABLE_LEN      = 14;

  localparam logic [43:0] MASK44    = 44'hFFFFFFFFFFF;
  localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;
  localparam logic [43:0] TENTH_Q24 = 44'd1677722;
  localparam logic [17:0] HUND_Q24  = 18'd167772;
  localparam logic [43:0] MICRO_Q24 = 44'd17;
  localparam logic [9:0]  MINRISE   = 10'd839;
  localparam logic [5:0]  SIGMA_RST = 6'd10;

  localparam logic [1:0] FLAG_IDLE = 2'd0;
  localparam logic [1:0] FLAG_WAIT = 2'd1;
  localparam logic [1:0] FLAG_NEW  = 2'd2;

  typedef struct packed {
    logic [3:0]  band;
    logic [19:0] magnitude;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  level;
    logic [1:0]  beat_state;
    logic        frame_beat;
    logic [19:0] decay_level;
  } out_item_t;

  // Divider request/response between the sequencer and the shared divider.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  function automatic logic [19:0] noise_floor(input logic [4:0] b);
    logic [19:0] v;
    case (b)
      5'd0: v = 20'd1584;   5'd1: v = 20'd1465;   5'd2: v = 20'd1298;
      5'd3: v = 20'd1011;   5'd4: v = 20'd1406;   5'd5: v = 20'd3387;
      5'd6: v = 20'd2072;   5'd7: v = 20'd1769;   5'd8: v = 20'd1115;
      5'd9: v = 20'd1362;   5'd10: v = 20'd1336;  5'd11: v = 20'd926;
      5'd12: v = 20'd1005;
      default: v = 20'd1041;
    endcase
    return v;
  endfunction

  function automatic logic [19:0] top_floor(input logic [4:0] b);
    logic [19:0] v;
    case (b)
      5'd0: v = 20'd44277;  5'd1: v = 20'd20888;  5'd2: v = 20'd35164;
      5'd3: v = 20'd16594;  5'd4: v = 20'd27446;  5'd5: v = 20'd19514;
      5'd6: v = 20'd18645;  5'd7: v = 20'd14826;  5'd8: v = 20'd10852;
      5'd9: v = 20'd15894;  5'd10: v = 20'd20048; 5'd11: v = 20'd9443;
      5'd12: v = 20'd9684;
      default: v = 20'd9152;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/blbt_div.sv -----
// Shared restoring divider, 64 by 64 bits, one quotient bit per cycle.
// Depends on blbt_pkg.
module blbt_div (
  input  logic               clk,
  input  logic               rst_n,
  input  blbt_pkg::div_req_t req,
  output blbt_pkg::div_rsp_t rsp
);
  import blbt_pkg::*;

  logic [63:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [64:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[63]} - {1'b0, den_r};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.num;
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[62:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (req.start) den_r <= req.den;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule

// ----- rtl/blbt_sqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
// Depends on blbt_pkg.
module blbt_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        done,
  output logic [31:0] root
);
  import blbt_pkg::*;

  logic [63:0] v_r, v_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      v_nxt    = rad;
      res_nxt  = '0;
      bit_nxt  = 64'h4000_0000_0000_0000;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (v_r >= res_r + bit_r) begin
        v_nxt   = v_r - (res_r + bit_r);
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = res_r[31:0];
endmodule

// ----- rtl/band_level_and_beat_tracker.sv -----
// Band level and beat tracker top level: sequencer, per-band state, APB register.
// Depends on blbt_pkg, blbt_div, blbt_sqrt.
// From input accept to out_valid: divides for min step, mean and second moment, a
// square root and a level divide; the min step divide is skipped on a band's first
// item, the level divide is not awaited when the level is set without it, and an
// out-of-range band goes straight out. in_ready stays low until the result is taken.
// Reset: synchronous active-low rst_n clears all band state, the vote and control.
module band_level_and_beat_tracker #(
  parameter int BAND_COUNT = blbt_pkg::BAND_COUNT_DEF,
  parameter int LEVEL_TOP  = blbt_pkg::LEVEL_TOP_DEF,
  parameter int VOTE_BANDS = blbt_pkg::VOTE_BANDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  blbt_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output blbt_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import blbt_pkg::*;

  localparam int BW = $clog2(BAND_COUNT);

  typedef enum logic [3:0] {
    S_IDLE, S_TRACK, S_MINDIV, S_MINWAIT, S_MEANDIV, S_MEANWAIT,
    S_E2DIV, S_E2WAIT, S_SQRT, S_SQWAIT, S_LVLDIV, S_LVLWAIT, S_OUT
  } state_t;

  // Per-band state in flip-flops, indexed by the item's band.
  logic [43:0] decay_r [BAND_COUNT];
  logic [43:0] maxt_r  [BAND_COUNT];
  logic [43:0] mint_r  [BAND_COUNT];
  logic [23:0] cnt_r   [BAND_COUNT];
  logic [43:0] sum_r   [BAND_COUNT];
  logic [63:0] sq_r    [BAND_COUNT];
  logic [5:0]  hold_r  [BAND_COUNT];
  logic [1:0]  flag_r  [BAND_COUNT];
  logic [2:0]  vsum_r;
  logic        vhit_r;
  logic [5:0]  sigma_r;

  state_t      st_r;
  logic [BW-1:0] b_r;
  logic [4:0]  bt_r;
  logic [19:0] m_r;
  logic        oob_r;
  logic [43:0] mean_r;
  logic [63:0] work_r;
  logic [31:0] sd_r;
  logic [19:0] x_r;
  logic [35:0] y_r;
  logic        out_valid_r;
  out_item_t   out_r;

  div_req_t    dreq;
  div_rsp_t    drsp;
  logic        sq_start, sq_done;
  logic [31:0] sq_root;

  blbt_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
  blbt_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .rad(work_r),
                    .done(sq_done), .root(sq_root));

  assign in_ready  = (st_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr == 2'd0) ? {26'd0, sigma_r} : 32'd0;

  function automatic logic [43:0] fall_t(input logic [43:0] t, input logic [43:0] mq);
    logic [61:0] p;
    logic [43:0] step;
    p = t * HUND_Q24;
    step = (p[61:24] < TENTH_Q24[37:0]) ? TENTH_Q24 : {6'd0, p[61:24]};
    if (mq >= t) return mq;
    return (t > step) ? t - step : 44'd0;
  endfunction

  // Combinational helpers for the current band.
  logic [43:0] mq;
  logic [63:0] mean_sq;
  logic [35:0] ksd;
  logic [43:0] thr;
  logic [19:0] nf, tf;
  logic [5:0]  lvl_raw;
  logic [44:0] min_add;
  logic        hit, fall;
  logic [1:0]  flag_new;
  logic [3:0]  vsum_add;

  assign mq      = {m_r, 24'd0};
  assign mean_sq = mean_r[31:0] * mean_r[31:0];
  assign ksd     = 36'((38'(sd_r) * 38'(sigma_r)) >> 2);
  assign thr     = mean_r + {8'd0, ksd};
  assign nf      = noise_floor(bt_r);
  assign tf      = top_floor(bt_r);
  assign hit     = (m_r != 20'd0) && ({16'd0, m_r, 8'd0} > thr);
  assign fall    = {16'd0, m_r, 8'd0} <= mean_r;

  always_comb begin
    flag_new = flag_r[b_r];
    if (hit) begin
      if (flag_new == FLAG_NEW) flag_new = FLAG_WAIT;
      else if (flag_new == FLAG_IDLE) flag_new = FLAG_NEW;
    end else begin
      if (flag_new == FLAG_NEW) flag_new = FLAG_WAIT;
      if (flag_new == FLAG_WAIT && fall) flag_new = FLAG_IDLE;
    end
    vsum_add = ((b_r == '0) ? 4'd0 : {1'b0, vsum_r}) + {2'd0, flag_new};
  end

  logic [19:0] x_c;
  logic [35:0] y_c;
  always_comb begin
    x_c = (mint_r[b_r][43:24] > nf) ? mint_r[b_r][43:24] : nf;
    y_c = {16'd0, (maxt_r[b_r][43:24] > tf) ? maxt_r[b_r][43:24] : tf};
    if (thr[43:8] > y_c) y_c = thr[43:8];
  end

  always_comb begin
    dreq = '0;
    sq_start = 1'b0;
    case (st_r)
      S_MINDIV: begin
        dreq.start = 1'b1;
        dreq.num   = {10'd0, 54'(sum_r[b_r]) * MINRISE};
        dreq.den   = {40'd0, cnt_r[b_r]};
      end
      S_MEANDIV: begin
        dreq.start = 1'b1;
        dreq.num   = {12'd0, sum_r[b_r], 8'd0};
        dreq.den   = {40'd0, cnt_r[b_r]};
      end
      S_E2DIV: begin
        dreq.start = 1'b1;
        dreq.num   = sq_r[b_r];
        dreq.den   = {40'd0, cnt_r[b_r]};
      end
      S_LVLDIV: begin
        dreq.start = 1'b1;
        dreq.num   = {44'd0, m_r - x_r} * LEVEL_TOP;
        dreq.den   = {28'd0, y_c - {16'd0, x_r}};
      end
      S_SQRT: sq_start = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    if (drsp.quo > LEVEL_TOP) lvl_raw = 6'(LEVEL_TOP);
    else lvl_raw = drsp.quo[5:0];
  end

  logic [5:0] lvl_sel;
  logic [63:0] inc;
  always_comb begin
    inc = (drsp.quo < {20'd0, MICRO_Q24}) ? {20'd0, MICRO_Q24} : drsp.quo;
    min_add = {1'b0, mint_r[b_r]} + inc[44:0];
    if (inc[63:45] != 0) min_add = {1'b1, 44'd0};
  end

  always_comb begin
    if (m_r < nf) lvl_sel = 6'd0;
    else if (y_r <= {16'd0, x_r}) lvl_sel = 6'(LEVEL_TOP);
    else if (m_r <= x_r) lvl_sel = 6'd0;
    else lvl_sel = lvl_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      sigma_r     <= SIGMA_RST;
      vsum_r      <= '0;
      vhit_r      <= 1'b0;
      for (int i = 0; i < BAND_COUNT; i++) begin
        decay_r[i] <= '0; maxt_r[i] <= '0; mint_r[i] <= '0; cnt_r[i] <= '0;
        sum_r[i] <= '0; sq_r[i] <= '0; hold_r[i] <= '0; flag_r[i] <= FLAG_IDLE;
      end
    end else begin
      if (psel && penable && pwrite && paddr == 2'd0) sigma_r <= pwdata[5:0];
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: if (in_valid && in_ready) begin
          m_r   <= in_data.magnitude;
          b_r   <= BW'(in_data.band);
          bt_r  <= (in_data.band < TABLE_LEN) ? {1'b0, in_data.band} : 5'(TABLE_LEN - 1);
          oob_r <= {28'd0, in_data.band} >= BAND_COUNT;
          st_r  <= S_TRACK;
        end
        S_TRACK: begin
          if (oob_r) begin
            out_r <= '0;
            out_valid_r <= 1'b1;
            st_r <= S_IDLE;
          end else begin
            decay_r[b_r] <= fall_t(decay_r[b_r], mq);
            maxt_r[b_r]  <= fall_t(maxt_r[b_r], mq);
            st_r <= (cnt_r[b_r] == '0) ? S_MINWAIT : S_MINDIV;
          end
        end
        S_MINDIV: st_r <= S_MINWAIT;
        S_MINWAIT: if (drsp.done || cnt_r[b_r] == '0) begin
          if (mq <= mint_r[b_r]) mint_r[b_r] <= mq;
          else if (cnt_r[b_r] == '0) mint_r[b_r] <= mint_r[b_r] + MICRO_Q24;
          else mint_r[b_r] <= min_add[44] ? MASK44 : min_add[43:0];
          if (cnt_r[b_r] != COUNT_MAX) begin
            cnt_r[b_r] <= cnt_r[b_r] + 24'd1;
            sum_r[b_r] <= sum_r[b_r] + {24'd0, m_r};
            sq_r[b_r]  <= sq_r[b_r] + {24'd0, 40'(m_r) * 40'(m_r)};
          end
          st_r <= S_MEANDIV;
        end
        S_MEANDIV: st_r <= S_MEANWAIT;
        S_MEANWAIT: if (drsp.done) begin
          mean_r <= drsp.quo[43:0];
          st_r <= S_E2DIV;
        end
        S_E2DIV: st_r <= S_E2WAIT;
        S_E2WAIT: if (drsp.done) begin
          st_r <= S_SQRT;
        end
        S_SQRT: begin
          st_r <= S_SQWAIT;
        end
        S_SQWAIT: if (sq_done) begin
          sd_r <= sq_root;
          x_r  <= x_c;
          st_r <= S_LVLDIV;
        end
        S_LVLDIV: begin
          y_r <= y_c;
          st_r <= S_LVLWAIT;
        end
        S_LVLWAIT: if (drsp.done || m_r < nf || y_r <= {16'd0, x_r} || m_r <= x_r) begin
          if (lvl_sel >= hold_r[b_r]) begin
            hold_r[b_r] <= lvl_sel;
            out_r.level <= lvl_sel;
          end else begin
            hold_r[b_r] <= hold_r[b_r] - 6'd1;
            out_r.level <= hold_r[b_r];
          end
          flag_r[b_r] <= flag_new;
          out_r.beat_state  <= flag_new;
          out_r.decay_level <= decay_r[b_r][43:24];
          out_r.frame_beat  <= 1'b0;
          if (32'(b_r) < VOTE_BANDS) begin
            vsum_r <= vsum_add[3] ? 3'd7 : vsum_add[2:0];
            vhit_r <= ((b_r == '0) ? 1'b0 : vhit_r) || (flag_new == FLAG_NEW);
            if (32'(b_r) == VOTE_BANDS - 1)
              out_r.frame_beat <= (vsum_add >= 4'd2) &&
                (((b_r == '0) ? 1'b0 : vhit_r) || (flag_new == FLAG_NEW));
          end
          out_valid_r <= 1'b1;
          st_r <= S_OUT;
        end
        S_OUT: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // Variance into the square-root radicand once the second moment is known.
  always_ff @(posedge clk) begin
    if (st_r == S_E2WAIT && drsp.done)
      work_r <= ({drsp.quo[47:0], 16'd0} > mean_sq) ? {drsp.quo[47:0], 16'd0} - mean_sq
                                                    : 64'd0;
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> st_r == S_IDLE) else $error("ready outside idle");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("second item taken");
  a_level_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.level <= LEVEL_TOP) else $error("level above top");
endmodule

// ----- sim/band_level_and_beat_tracker_tb.sv -----
// Testbench for band_level_and_beat_tracker: random band streams, APB register writes,
// scoreboard predicting level, beat state, frame vote and decay level per transaction.
// Depends on blbt_pkg and the band_level_and_beat_tracker RTL.
`timescale 1ns / 1ps

module band_level_and_beat_tracker_tb;
  import blbt_pkg::*;

  localparam int NB = 14;
  localparam int LTOP = 60;
  localparam int NVOTE = 4;

  class band_meter_board;
    logic [43:0] decay_q[NB];
    logic [43:0] peak_q[NB];
    logic [43:0] floor_q[NB];
    logic [23:0] n_cnt[NB];
    logic [43:0] s_sum[NB];
    logic [63:0] sq_sum[NB];
    logic [5:0]  held[NB];
    logic [1:0]  flag_st[NB];
    int unsigned votes;
    bit          vote_new;
    logic [5:0]  k4;
    out_item_t   pending[$];
    int unsigned errors;
    int unsigned checked;

    function void clear();
      for (int i = 0; i < NB; i++) begin
        decay_q[i] = '0; peak_q[i] = '0; floor_q[i] = '0; n_cnt[i] = '0;
        s_sum[i] = '0; sq_sum[i] = '0; held[i] = '0; flag_st[i] = FLAG_IDLE;
      end
      votes = 0; vote_new = 0; k4 = SIGMA_RST;
      errors = 0; checked = 0;
    endfunction

    function logic [63:0] root64(logic [63:0] v);
      logic [63:0] r, b;
      r = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b; r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function logic [63:0] decline(logic [63:0] t, logic [63:0] mq);
      logic [63:0] st;
      if (mq >= t) return mq;
      st = (t * 64'd167772) >> 24;
      if (st < 64'd1677722) st = 64'd1677722;
      return t > st ? t - st : 64'd0;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      int b;
      logic [63:0] m, mq, inc, mean, e2, var_q, msq, sd, thr, x, y, lvl, s;
      logic [63:0] nf, tf;
      logic [1:0] fl;
      bit hit, fall;
      r = '0;
      b = it.band;
      m = it.magnitude;
      if (b >= NB) begin
        pending.push_back(r);
        return;
      end
      mq = m << 24;
      decay_q[b] = decline(decay_q[b], mq);
      peak_q[b] = decline(peak_q[b], mq);
      inc = (n_cnt[b] != 0) ? (64'(s_sum[b]) * 64'd839) / n_cnt[b] : 64'd0;
      if (inc < 17) inc = 17;
      if (mq <= floor_q[b]) floor_q[b] = mq;
      else begin
        s = floor_q[b] + inc;
        floor_q[b] = (s > 64'hFFFFFFFFFFF) ? 44'hFFFFFFFFFFF : s[43:0];
      end
      if (n_cnt[b] < COUNT_MAX) begin
        n_cnt[b]++; s_sum[b] += m; sq_sum[b] += m * m;
      end
      mean = (64'(s_sum[b]) << 8) / n_cnt[b];
      e2 = sq_sum[b] / n_cnt[b];
      msq = mean * mean;
      var_q = ((e2 << 16) > msq) ? (e2 << 16) - msq : 64'd0;
      sd = root64(var_q);
      thr = mean + ((64'(k4) * sd) >> 2);
      nf = noise_floor(5'(b)); tf = top_floor(5'(b));
      x = nf;
      if ((floor_q[b] >> 24) > x) x = floor_q[b] >> 24;
      y = tf;
      if ((peak_q[b] >> 24) > y) y = peak_q[b] >> 24;
      if ((thr >> 8) > y) y = thr >> 8;
      if (m < nf) lvl = 0;
      else if (y <= x) lvl = LTOP;
      else if (m <= x) lvl = 0;
      else begin
        lvl = ((m - x) * LTOP) / (y - x);
        if (lvl > LTOP) lvl = LTOP;
      end
      if (lvl >= held[b]) held[b] = lvl[5:0];
      else begin
        lvl = held[b]; held[b]--;
      end
      hit = (m >= 1) && ((m << 8) > thr);
      fall = (m << 8) <= mean;
      fl = flag_st[b];
      if (hit) begin
        if (fl == FLAG_NEW) fl = FLAG_WAIT;
        else if (fl == FLAG_IDLE) fl = FLAG_NEW;
      end else begin
        if (fl == FLAG_NEW) fl = FLAG_WAIT;
        if (fl == FLAG_WAIT && fall) fl = FLAG_IDLE;
      end
      flag_st[b] = fl;
      if (b < NVOTE) begin
        if (b == 0) begin
          votes = 0; vote_new = 0;
        end
        votes += fl;
        if (votes > 7) votes = 7;
        if (fl == FLAG_NEW) vote_new = 1;
        if (b == NVOTE - 1) r.frame_beat = (votes >= 2) && vote_new;
      end
      r.level = lvl[5:0];
      r.beat_state = fl;
      r.decay_level = decay_q[b][43:24];
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      e = pending.pop_front();
      if (got.level !== e.level || got.beat_state !== e.beat_state ||
          got.frame_beat !== e.frame_beat || got.decay_level !== e.decay_level) begin
        errors++;
        if (errors <= 10)
          $display("mismatch #%0d: exp lvl=%0d st=%0d fb=%0d dec=%0d, %s",
                   checked, e.level, e.beat_state, e.frame_beat, e.decay_level,
                   $sformatf("got lvl=%0d st=%0d fb=%0d dec=%0d",
                             got.level, got.beat_state, got.frame_beat,
                             got.decay_level));
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  band_meter_board board = new();
  bit calm = 0;
  int unsigned sent = 0;

  band_level_and_beat_tracker uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Receiver: stall in bursts, check each accepted transaction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 11);
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
    end
  end

  task automatic send_item(logic [3:0] b, logic [19:0] m);
    in_item_t it;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    it.band = b; it.magnitude = m;
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(it);
    sent++;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_sigma(logic [5:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 2'd0; pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.k4 = v;
  endtask

  // One magnitude: half moderate, the rest quiet, random or loud to trigger beats.
  function automatic logic [19:0] pick_mag();
    case ($urandom_range(0, 9))
      0: return 20'($urandom_range(0, 2000));
      1: return 20'($urandom);
      2: return 20'hFFFFF;
      3, 4: return 20'($urandom_range(200000, 900000));
      default: return 20'($urandom_range(1000, 60000));
    endcase
  endfunction

  task automatic send_frames(int nframes);
    for (int f = 0; f < nframes; f++)
      for (int b = 0; b < NB; b++) begin
        if ($urandom_range(0, 39) == 0) send_item(4'($urandom_range(0, 15)), 20'($urandom));
        else send_item(4'(b), pick_mag());
      end
    in_valid <= 0;
  endtask

  initial begin
    logic [5:0] ks[4];
    board.clear();
    ks[0] = 6'd0; ks[1] = 6'd63; ks[2] = 6'd4; ks[3] = 6'd10;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes, empty span, out-of-range bands, out-of-order vote
    send_item(4'd0, 20'd0);
    send_item(4'd0, 20'hFFFFF);
    send_item(4'd1, 20'd1465);
    send_item(4'd1, 20'd1464);
    send_item(4'd2, 20'hFFFFF);
    send_item(4'd3, 20'hFFFFF);
    send_item(4'd14, 20'hFFFFF);
    send_item(4'd15, 20'h55555);
    send_item(4'd13, 20'hAAAAA);
    send_item(4'd3, 20'd0);
    send_item(4'd12, 20'd1);
    send_item(4'd0, 20'd44277);
    send_item(4'd2, 20'd1);
    send_item(4'd3, 20'hFFFFF);
    in_valid <= 0;
    drain();
    for (int p = 0; p < 4; p++) begin
      write_sigma(ks[p]);
      send_frames(12);
      drain();
      write_sigma(6'($urandom_range(0, 63)));
      send_frames(8);
      drain();
    end
    calm = 1;
    send_frames(2);
    drain();
    $display("Sent %0d transactions over several sigma settings; %0d results checked, %0d errors.",
             sent, board.checked, board.errors);
    if (board.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #50000000;
    $display("Verification failed");
    $finish;
  end
endmodule
